@@ sv/bsp_pkg.sv @@
// shared types, constants and arithmetic helpers for the background subtraction block
`timescale 1ns / 1ps
`default_nettype none
package bsp_pkg;

  localparam int MAX_PIXELS = 524288;
  localparam int POS_W      = $clog2(MAX_PIXELS);
  localparam int FILL_W     = $clog2(MAX_PIXELS + 1);
  localparam int CNT_W      = 16;
  localparam int PIX_W      = 24;
  localparam int GP_W       = 22;
  localparam int SQ_W       = 16;
  localparam int DIST_W     = 18;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [GP_W-1:0] GRAY_R_C = GP_W'(4899);
  localparam logic [GP_W-1:0] GRAY_G_C = GP_W'(9617);
  localparam logic [GP_W-1:0] GRAY_B_C = GP_W'(1868);

  localparam logic [CFG_IDX_W-1:0] CFG_DIFF_THR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_W   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OBJ_THR   = 2'd3;

  localparam logic [7:0]       DIFF_THR_RST  = 8'd50;
  localparam logic [CNT_W-1:0] COUNT_THR_RST = 16'd20;
  localparam logic [8:0]       BLEND_W_RST   = 9'd77;
  localparam logic [7:0]       OBJ_THR_RST   = 8'd60;
  localparam logic [8:0]       BLEND_W_MAX   = 9'd256;
  localparam logic [CNT_W-1:0] CNT_RST       = 16'd1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic [GP_W-1:0] pr;
    logic [GP_W-1:0] pg;
    logic [GP_W-1:0] pb;
  } gprod_t;

  typedef struct packed {
    logic [7:0]       diff_thr;
    logic [CNT_W-1:0] count_thr;
    logic [8:0]       blend_w;
    logic [7:0]       obj_thr;
    logic [SQ_W-1:0]  thr_sq;
  } bsp_cfg_t;

  typedef struct packed {
    logic             bg_en;
    logic             cnt_en;
    logic [POS_W-1:0] addr;
    pix_t             bg;
    logic [CNT_W-1:0] cnt;
  } bsp_wr_t;

  typedef struct packed {
    logic object_bit;
    logic last_of_frame;
  } bsp_res_t;

  function automatic logic [7:0] absdiff8(input logic [7:0] a, input logic [7:0] b);
    absdiff8 = (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic gprod_t gray_prods(input pix_t d);
    gprod_t p;
    p.pr = GRAY_R_C * GP_W'(d.red);
    p.pg = GRAY_G_C * GP_W'(d.green);
    p.pb = GRAY_B_C * GP_W'(d.blue);
    gray_prods = p;
  endfunction

  function automatic logic [7:0] gray_round(input gprod_t p);
    logic [GP_W:0] s;
    s = (GP_W+1)'(p.pr) + (GP_W+1)'(p.pg) + (GP_W+1)'(p.pb) + (GP_W+1)'(8192);
    gray_round = s[21:14];
  endfunction

  function automatic logic [7:0] blend_chan(input logic [7:0] bg, input logic [7:0] f,
                                            input logic [8:0] w);
    logic [16:0] t0;
    logic [16:0] t1;
    logic [9:0]  s;
    t0 = 17'(w) * 17'(bg);
    t1 = 17'(BLEND_W_MAX - w) * 17'(f);
    s  = 10'((t0 + 17'd128) >> 8) + 10'((t1 + 17'd128) >> 8);
    blend_chan = (s > 10'd255) ? 8'd255 : s[7:0];
  endfunction

  function automatic pix_t pix_absdiff(input pix_t a, input pix_t b);
    pix_t d;
    d.red   = absdiff8(a.red, b.red);
    d.green = absdiff8(a.green, b.green);
    d.blue  = absdiff8(a.blue, b.blue);
    pix_absdiff = d;
  endfunction

endpackage
`default_nettype wire

@@ sv/bsp_ram.sv @@
// simple dual-port ram with registered read and read enable
`timescale 1ns / 1ps
`default_nettype none
module bsp_ram #(
  parameter int DATA_W = 24,
  parameter int DEPTH  = 524288
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [DATA_W-1:0]        wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [DATA_W-1:0]        rd_data_r
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ sv/bsp_pipe.sv @@
// four-stage pixel datapath: difference, update decision, re-difference, object test
`timescale 1ns / 1ps
`default_nettype none
module bsp_pipe (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     run,
  input  wire logic                     accept,
  input  wire bsp_pkg::pix_t            in_pix,
  input  wire logic                     in_fe,
  input  wire logic                     in_loaded,
  input  wire logic                     in_cnt_valid,
  input  wire logic [bsp_pkg::POS_W-1:0] in_pos,
  input  wire bsp_pkg::pix_t            bg_rd,
  input  wire logic [bsp_pkg::CNT_W-1:0] cnt_rd,
  input  wire bsp_pkg::bsp_cfg_t        cfg,
  output logic                          hazard,
  output bsp_pkg::bsp_wr_t              wr,
  output logic                          push,
  output bsp_pkg::bsp_res_t             res
);
  import bsp_pkg::*;

  // stage 1
  logic             s1_v_r, s1_fe_r, s1_ld_r, s1_cv_r;
  pix_t             s1_pix_r;
  logic [POS_W-1:0] s1_pos_r;
  // stage 2
  logic             s2_v_r, s2_fe_r, s2_ld_r;
  pix_t             s2_pix_r, s2_bg_r, s2_bl_r;
  logic [POS_W-1:0] s2_pos_r;
  logic [CNT_W-1:0] s2_cnt_r;
  gprod_t           s2_gp_r;
  logic [SQ_W-1:0]  s2_sqr_r, s2_sqg_r, s2_sqb_r;
  // stage 3
  logic             s3_v_r, s3_fe_r, s3_ld_r;
  pix_t             s3_pix_r, s3_nb_r;
  logic [POS_W-1:0] s3_pos_r;
  logic [CNT_W-1:0] s3_cnt_r;
  // stage 4
  logic             s4_v_r, s4_fe_r, s4_ld_r;
  gprod_t           s4_gp_r;

  logic [CNT_W-1:0]  s1_cnt;
  pix_t              s1_d, s1_bl;
  logic [7:0]        s2_gray;
  logic [DIST_W-1:0] s2_dist;
  logic [CNT_W-1:0]  s2_cnt_nxt;
  pix_t              s2_nb;
  pix_t              s3_d;

  assign hazard = (s1_v_r && (s1_pos_r == in_pos)) ||
                  (s2_v_r && (s2_pos_r == in_pos)) ||
                  (s3_v_r && (s3_pos_r == in_pos));

  always_comb begin
    s1_cnt      = s1_cv_r ? cnt_rd : CNT_RST;
    s1_d        = pix_absdiff(s1_pix_r, bg_rd);
    s1_bl.red   = blend_chan(bg_rd.red, s1_pix_r.red, cfg.blend_w);
    s1_bl.green = blend_chan(bg_rd.green, s1_pix_r.green, cfg.blend_w);
    s1_bl.blue  = blend_chan(bg_rd.blue, s1_pix_r.blue, cfg.blend_w);
  end

  always_comb begin
    s2_gray    = gray_round(s2_gp_r);
    s2_dist    = DIST_W'(s2_sqr_r) + DIST_W'(s2_sqg_r) + DIST_W'(s2_sqb_r);
    s2_cnt_nxt = (s2_dist > DIST_W'(cfg.thr_sq)) ? (s2_cnt_r + CNT_W'(1)) : s2_cnt_r;
    if (!s2_ld_r) begin
      s2_nb = s2_pix_r;
    end else if (s2_gray > cfg.diff_thr) begin
      s2_nb = (s2_cnt_nxt > cfg.count_thr) ? s2_pix_r : s2_bg_r;
    end else begin
      s2_nb = s2_bl_r;
    end
  end

  assign s3_d = pix_absdiff(s3_pix_r, s3_nb_r);

  always_comb begin
    wr.bg_en  = run && s3_v_r;
    wr.cnt_en = run && s3_v_r && s3_ld_r;
    wr.addr   = s3_pos_r;
    wr.bg     = s3_nb_r;
    wr.cnt    = s3_cnt_r;
  end

  assign push           = run && s4_v_r && s4_ld_r;
  assign res.object_bit = (gray_round(s4_gp_r) > cfg.obj_thr);
  assign res.last_of_frame = s4_fe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else if (run) begin
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      s1_pix_r <= in_pix;
      s1_fe_r  <= in_fe;
      s1_ld_r  <= in_loaded;
      s1_cv_r  <= in_cnt_valid;
      s1_pos_r <= in_pos;

      s2_pix_r <= s1_pix_r;
      s2_bg_r  <= bg_rd;
      s2_bl_r  <= s1_bl;
      s2_fe_r  <= s1_fe_r;
      s2_ld_r  <= s1_ld_r;
      s2_pos_r <= s1_pos_r;
      s2_cnt_r <= s1_cnt;
      s2_gp_r  <= gray_prods(s1_d);
      s2_sqr_r <= SQ_W'(s1_d.red) * SQ_W'(s1_d.red);
      s2_sqg_r <= SQ_W'(s1_d.green) * SQ_W'(s1_d.green);
      s2_sqb_r <= SQ_W'(s1_d.blue) * SQ_W'(s1_d.blue);

      s3_pix_r <= s2_pix_r;
      s3_nb_r  <= s2_nb;
      s3_fe_r  <= s2_fe_r;
      s3_ld_r  <= s2_ld_r;
      s3_pos_r <= s2_pos_r;
      s3_cnt_r <= s2_cnt_nxt;

      s4_gp_r  <= gray_prods(s3_d);
      s4_fe_r  <= s3_fe_r;
      s4_ld_r  <= s3_ld_r;
    end
  end

endmodule
`default_nettype wire

@@ sv/bsp_out_fifo.sv @@
// four-entry result queue between the datapath and the output channel
`timescale 1ns / 1ps
`default_nettype none
module bsp_out_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire bsp_pkg::bsp_res_t push_data,
  output logic                   not_full,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output bsp_pkg::bsp_res_t      out_data
);
  import bsp_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  bsp_res_t         mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   count_r;
  logic             pop;

  assign not_full  = (count_r != (PTR_W+1)'(DEPTH));
  assign out_valid = (count_r != '0);
  assign out_data  = mem[rd_ptr_r];
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (PTR_W+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (PTR_W+1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/background_subtraction_pixel.sv @@
// top level of the per-pixel running-average background subtraction block
//
// Pixels enter on the in_ channel (valid/stall) in raster order, one per
// transaction, with in_frame_end set on the last pixel of each frame. The
// first frame is only stored as background and gives no result; every later
// pixel gives one out_ transaction with the object bit and a copy of the
// frame end flag. Configuration registers are written through cfg_wr_en,
// cfg_index and cfg_data; the user must write them only while the block is
// idle, which the block itself does not enforce.
// Throughput: one pixel per cycle. A pixel is held off only while its pixel
// position is still being updated by an earlier pixel (frames shorter than
// four pixels) or while the four-entry result queue is full.
// Reset (synchronous, rst_n low) clears position, frame state, the queue and
// restores register defaults; change counts read as one until first written,
// tracked by a fill counter, so no clearing pass is needed.
// When out_stall is high results collect in the queue; once it is full the
// whole datapath holds and in_stall rises.
`timescale 1ns / 1ps
`default_nettype none
module background_subtraction_pixel (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [7:0]                      in_blue,
  input  wire logic [7:0]                      in_green,
  input  wire logic [7:0]                      in_red,
  input  wire logic                            in_frame_end,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_object_bit,
  output logic                                 out_last_of_frame,
  input  wire logic                            cfg_wr_en,
  input  wire logic [bsp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bsp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bsp_pkg::*;

  logic [7:0]       diff_thr_r, obj_thr_r;
  logic [CNT_W-1:0] count_thr_r;
  logic [8:0]       blend_w_r;
  logic [SQ_W-1:0]  thr_sq_r;

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [FILL_W-1:0] fill_r;
  logic              loaded_r;

  logic     run, hazard, accept, cnt_valid, push;
  pix_t     in_pix, bg_rd;
  logic [CNT_W-1:0] cnt_rd;
  bsp_cfg_t cfg;
  bsp_wr_t  wr;
  bsp_res_t res, out_res;

  assign in_pix.red   = in_red;
  assign in_pix.green = in_green;
  assign in_pix.blue  = in_blue;

  assign in_stall  = !run || hazard;
  assign accept    = in_valid && !in_stall;
  assign cnt_valid = (FILL_W'(pos_r) < fill_r);
  assign pos_nxt   = (pos_r == POS_W'(MAX_PIXELS - 1)) ? '0 : (pos_r + POS_W'(1));

  always_comb begin
    cfg.diff_thr  = diff_thr_r;
    cfg.count_thr = count_thr_r;
    cfg.blend_w   = (blend_w_r > BLEND_W_MAX) ? BLEND_W_MAX : blend_w_r;
    cfg.obj_thr   = obj_thr_r;
    cfg.thr_sq    = thr_sq_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff_thr_r  <= DIFF_THR_RST;
      count_thr_r <= COUNT_THR_RST;
      blend_w_r   <= BLEND_W_RST;
      obj_thr_r   <= OBJ_THR_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_DIFF_THR:  diff_thr_r  <= cfg_data[7:0];
        CFG_COUNT_THR: count_thr_r <= cfg_data[CNT_W-1:0];
        CFG_BLEND_W:   blend_w_r   <= cfg_data[8:0];
        CFG_OBJ_THR:   obj_thr_r   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    thr_sq_r <= SQ_W'(diff_thr_r) * SQ_W'(diff_thr_r);
  end

  // position tracking and fill count of the change count store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      fill_r   <= '0;
      loaded_r <= 1'b0;
    end else if (accept) begin
      if (loaded_r && (FILL_W'(pos_r) == fill_r)) begin
        fill_r <= fill_r + FILL_W'(1);
      end
      if (in_frame_end) begin
        pos_r    <= '0;
        loaded_r <= 1'b1;
      end else begin
        pos_r <= pos_nxt;
      end
    end
  end

  bsp_ram #(
    .DATA_W(PIX_W),
    .DEPTH (MAX_PIXELS)
  ) u_bg_ram (
    .clk      (clk),
    .wr_en    (wr.bg_en),
    .wr_addr  (wr.addr),
    .wr_data  (wr.bg),
    .rd_en    (run),
    .rd_addr  (pos_r),
    .rd_data_r(bg_rd)
  );

  bsp_ram #(
    .DATA_W(CNT_W),
    .DEPTH (MAX_PIXELS)
  ) u_cnt_ram (
    .clk      (clk),
    .wr_en    (wr.cnt_en),
    .wr_addr  (wr.addr),
    .wr_data  (wr.cnt),
    .rd_en    (run),
    .rd_addr  (pos_r),
    .rd_data_r(cnt_rd)
  );

  bsp_pipe u_pipe (
    .clk         (clk),
    .rst_n       (rst_n),
    .run         (run),
    .accept      (accept),
    .in_pix      (in_pix),
    .in_fe       (in_frame_end),
    .in_loaded   (loaded_r),
    .in_cnt_valid(cnt_valid),
    .in_pos      (pos_r),
    .bg_rd       (bg_rd),
    .cnt_rd      (cnt_rd),
    .cfg         (cfg),
    .hazard      (hazard),
    .wr          (wr),
    .push        (push),
    .res         (res)
  );

  bsp_out_fifo u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(res),
    .not_full (run),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_res)
  );

  assign out_object_bit    = out_res.object_bit;
  assign out_last_of_frame = out_res.last_of_frame;

endmodule
`default_nettype wire
